// ----- rtl/sltbl_pkg.sv -----
// ----------------------------------------------------------------------------
// sltbl_pkg
// shared types, widths and codes for the sorted leaf node table
// ----------------------------------------------------------------------------
package sltbl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int KEY_W    = 32;
  localparam int REC_W    = 31;
  localparam int ENTRY_W  = KEY_W + REC_W + REC_W;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOCATE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // request to the shared compare unit
  typedef struct packed {
    logic signed [KEY_W-1:0] key_a;
    logic signed [KEY_W-1:0] key_b;
    logic [CNT_W-1:0]        idx_a;
    logic [CNT_W-1:0]        idx_b;
  } cmp_req_t;

  // answer from the shared compare unit
  typedef struct packed {
    logic key_lt;
    logic idx_lt;
    logic idx_eq;
  } cmp_res_t;

endpackage

// ----- rtl/sltbl_ram.sv -----
// ----------------------------------------------------------------------------
// sltbl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sltbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/sltbl_cmp.sv -----
// ----------------------------------------------------------------------------
// sltbl_cmp
// shared compare unit: signed key order and entry index order
// ----------------------------------------------------------------------------
module sltbl_cmp (
  input  sltbl_pkg::cmp_req_t req,
  output sltbl_pkg::cmp_res_t res
);

  always_comb begin
    res.key_lt = req.key_a < req.key_b;
    res.idx_lt = req.idx_a < req.idx_b;
    res.idx_eq = req.idx_a == req.idx_b;
  end

endmodule

// ----- rtl/sorted_leaf_node_table.sv -----
// ----------------------------------------------------------------------------
// sorted_leaf_node_table
// one b+tree leaf node: sorted entries of signed key and record id
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one operation per transaction:
//   insert, locate or read entry. output channel (out_valid/out_ready)
//   returns exactly one result transaction for every input transaction.
//   entries sit in one ram (key, page, slot side by side) kept in ascending
//   key order; a single compare unit is stepped over them by the sequencer.
// steps, from acceptance to result valid
//   insert : from the top down, read and compare, moving each entry up
//            until a smaller key is met; then the new entry is written
//   locate : upward from entry 0, read and compare until a key not below
//            the search key is met or the count is reached
//   read   : address, then data; full insert, bad index, unused code: done
//   each compare has a read state ahead of it, as the ram read is registered.
//   one operation is in flight at a time: in_ready is high only while idle.
// reset
//   clears the entry count and the output valid; the ram is not cleared, as
//   only entries below the count are ever used.
// stalls
//   the result is held in an output register; a finished result waits in
//   the done state until the output register is free, so nothing is lost.
// ----------------------------------------------------------------------------
module sorted_leaf_node_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic signed [31:0] key,
  input  logic [30:0] rec_page,
  input  logic [30:0] rec_slot,
  input  logic [5:0]  entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  found_index,
  output logic signed [31:0] out_key,
  output logic [30:0] out_page,
  output logic [30:0] out_slot,
  output logic [6:0]  entry_count
);

  localparam int IDX_W   = sltbl_pkg::IDX_W;
  localparam int CNT_W   = sltbl_pkg::CNT_W;
  localparam int KEY_W   = sltbl_pkg::KEY_W;
  localparam int REC_W   = sltbl_pkg::REC_W;
  localparam int ENTRY_W = sltbl_pkg::ENTRY_W;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS_RD  = 9'b000000010,
    S_INS_CMP = 9'b000000100,
    S_INS_WR  = 9'b000001000,
    S_LOC_RD  = 9'b000010000,
    S_LOC_CMP = 9'b000100000,
    S_RD_ADDR = 9'b001000000,
    S_RD_DATA = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0] count, count_next;   // entries held
  logic [CNT_W-1:0] cur, cur_next;       // scan / shift cursor
  logic             out_vld, out_vld_next;

  // latched operation
  logic signed [KEY_W-1:0] op_key;
  logic [REC_W-1:0]        op_page;
  logic [REC_W-1:0]        op_slot;
  logic [IDX_W-1:0]        op_idx;

  // pending result
  logic [1:0]              res_status, res_status_next;
  logic [IDX_W-1:0]        res_found, res_found_next;
  logic signed [KEY_W-1:0] res_key, res_key_next;
  logic [REC_W-1:0]        res_page, res_page_next;
  logic [REC_W-1:0]        res_slot, res_slot_next;

  // ram port
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  logic signed [KEY_W-1:0] rd_key;
  logic [REC_W-1:0]        rd_page;
  logic [REC_W-1:0]        rd_slot;

  sltbl_pkg::cmp_req_t cmp_req;
  sltbl_pkg::cmp_res_t cmp_res;

  logic in_fire;
  logic out_load;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_vld;

  assign rd_key  = rd_data[ENTRY_W-1 -: KEY_W];
  assign rd_page = rd_data[2*REC_W-1 -: REC_W];
  assign rd_slot = rd_data[REC_W-1:0];

  // entry storage
  sltbl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (sltbl_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared compare unit: stored key against operation key, and an index
  // (entry_index while idle, the cursor otherwise) against the count
  always_comb begin
    cmp_req.key_a = rd_key;
    cmp_req.key_b = op_key;
    cmp_req.idx_a = (state == S_IDLE) ? CNT_W'(entry_index) : cur;
    cmp_req.idx_b = count;
  end

  sltbl_cmp u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    cur_next        = cur;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_key_next    = res_key;
    res_page_next   = res_page;
    res_slot_next   = res_slot;
    wr_en           = 1'b0;
    wr_addr         = cur[IDX_W-1:0];
    wr_data         = rd_data;
    rd_addr         = cur[IDX_W-1:0];
    out_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          // default result: no such record, all payload zero
          res_status_next = sltbl_pkg::ST_NONE;
          res_found_next  = '0;
          res_key_next    = '0;
          res_page_next   = '0;
          res_slot_next   = '0;
          unique case (func)
            sltbl_pkg::FUNC_INSERT: begin
              if (count == CNT_W'(sltbl_pkg::CAPACITY)) begin
                res_status_next = sltbl_pkg::ST_FULL;
                state_next      = S_DONE;
              end else begin
                // shift from the top down until a smaller key is met
                cur_next   = count;
                state_next = (count == '0) ? S_INS_WR : S_INS_RD;
              end
            end
            sltbl_pkg::FUNC_LOCATE: begin
              cur_next   = '0;
              state_next = S_LOC_RD;
            end
            sltbl_pkg::FUNC_READ: begin
              state_next = cmp_res.idx_lt ? S_RD_ADDR : S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_INS_RD: begin
        rd_addr    = IDX_W'(cur - CNT_W'(1));
        state_next = S_INS_CMP;
      end

      S_INS_CMP: begin
        if (!cmp_res.key_lt) begin
          // stored key not below the new one: move it up one place
          wr_en      = 1'b1;
          wr_addr    = cur[IDX_W-1:0];
          wr_data    = rd_data;
          cur_next   = cur - CNT_W'(1);
          state_next = (cur == CNT_W'(1)) ? S_INS_WR : S_INS_RD;
        end else begin
          state_next = S_INS_WR;
        end
      end

      S_INS_WR: begin
        wr_en           = 1'b1;
        wr_addr         = cur[IDX_W-1:0];
        wr_data         = {op_key, op_page, op_slot};
        count_next      = count + CNT_W'(1);
        res_status_next = sltbl_pkg::ST_OK;
        res_found_next  = cur[IDX_W-1:0];
        state_next      = S_DONE;
      end

      S_LOC_RD: begin
        // past the last entry: no such record
        rd_addr    = cur[IDX_W-1:0];
        state_next = cmp_res.idx_eq ? S_DONE : S_LOC_CMP;
      end

      S_LOC_CMP: begin
        if (cmp_res.key_lt) begin
          cur_next   = cur + CNT_W'(1);
          state_next = S_LOC_RD;
        end else begin
          res_status_next = sltbl_pkg::ST_OK;
          res_found_next  = cur[IDX_W-1:0];
          state_next      = S_DONE;
        end
      end

      S_RD_ADDR: begin
        rd_addr    = op_idx;
        state_next = S_RD_DATA;
      end

      S_RD_DATA: begin
        res_status_next = sltbl_pkg::ST_OK;
        res_found_next  = op_idx;
        res_key_next    = rd_key;
        res_page_next   = rd_page;
        res_slot_next   = rd_slot;
        state_next      = S_DONE;
      end

      S_DONE: begin
        // hand over once the output register is free
        if (!out_vld || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_vld_next = 1'b1;
    end else if (out_ready) begin
      out_vld_next = 1'b0;
    end else begin
      out_vld_next = out_vld;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      cur     <= '0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cur     <= cur_next;
      out_vld <= out_vld_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_key  <= key;
      op_page <= rec_page;
      op_slot <= rec_slot;
      op_idx  <= entry_index;
    end
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_key    <= res_key_next;
    res_page   <= res_page_next;
    res_slot   <= res_slot_next;
    if (out_load) begin
      status      <= res_status;
      found_index <= res_found;
      out_key     <= res_key;
      out_page    <= res_page;
      out_slot    <= res_slot;
      entry_count <= count;
    end
  end

  // the count never passes the node capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(sltbl_pkg::CAPACITY))
    else $error("entry count above capacity");

  // the count moves only on the final insert write, and then by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_INS_WR) |=> (count == $past(count)))
    else $error("entry count changed outside insert");

  // the ram is written only while an insert is in progress
  a_write_insert: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_INS_CMP || state == S_INS_WR))
    else $error("ram write outside insert");

  // a full report is only given for a full node
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (out_vld && status == sltbl_pkg::ST_FULL) |->
      (entry_count == CNT_W'(sltbl_pkg::CAPACITY)))
    else $error("full reported on a node with room");

  // a loaded result always appears valid in the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_vld)
    else $error("loaded result not valid");

endmodule

// ----- dv/tb_sorted_leaf_node_table.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_leaf_node_table
// self-checking bench for the sorted leaf node table
// ----------------------------------------------------------------------------
// a queue of operations is built up front: a short directed run over the
// corner cases (empty node, extreme keys, equal keys, reads past the count,
// the unused operation code), then a random run that fills the node, keeps
// hitting it once full and mixes in locates and reads around stored keys.
// a driver presents one transaction at a time on the falling edge; a mirror
// of the leaf node works out each expected result when the input is
// accepted, and a monitor checks every output transaction against the
// oldest expected result on the rising edge.
// ----------------------------------------------------------------------------
module tb_sorted_leaf_node_table;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_OPS   = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TIME  = 2 * sltbl_pkg::CAPACITY + 8;
  localparam int MAX_REPORTS  = 10;

  // one operation as presented on the input channel
  typedef struct {
    logic [1:0]  func;
    logic [31:0] key;
    logic [30:0] page;
    logic [30:0] slot;
    logic [5:0]  idx;
    bit          drain;  // hold off until every expected result has come
    int          phase;  // idling phase this operation belongs to
  } leaf_op_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_index;
    logic [31:0] out_key;
    logic [30:0] out_page;
    logic [30:0] out_slot;
    logic [6:0]  entry_count;
  } leaf_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         func;
  logic signed [31:0] key;
  logic [30:0]        rec_page;
  logic [30:0]        rec_slot;
  logic [5:0]         entry_index;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [5:0]         found_index;
  logic signed [31:0] out_key;
  logic [30:0]        out_page;
  logic [30:0]        out_slot;
  logic [6:0]         entry_count;

  sorted_leaf_node_table DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .key         (key),
    .rec_page    (rec_page),
    .rec_slot    (rec_slot),
    .entry_index (entry_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_index (found_index),
    .out_key     (out_key),
    .out_page    (out_page),
    .out_slot    (out_slot),
    .entry_count (entry_count)
  );

  // operations still to be presented, and results still owed by the block
  leaf_op_t     op_queue[$];
  leaf_result_t owed_results[$];

  // mirror of the leaf node contents
  logic signed [31:0] node_keys  [sltbl_pkg::CAPACITY];
  logic [30:0]        node_pages [sltbl_pkg::CAPACITY];
  logic [30:0]        node_slots [sltbl_pkg::CAPACITY];
  int                 node_used;

  // generation-time bookkeeping: the fill level is exact as nothing is removed
  logic [31:0] key_pool[$];
  int          gen_used;

  int n_presented;
  int n_accepted;
  int mismatch_cnt;
  int cycle_cnt;
  int cur_phase;
  int send_idle [3] = '{33, 60, 0};
  int recv_idle [3] = '{60, 33, 0};

  // --------------------------------------------------------------------------
  // leaf node mirror: applies one operation and returns the result it gives
  // --------------------------------------------------------------------------
  function automatic leaf_result_t leaf_node_apply(logic [1:0] op, logic [31:0] k,
                                                   logic [30:0] pg, logic [30:0] sl,
                                                   logic [5:0] ix);
    leaf_result_t res;
    int           pos;
    res = '0;
    res.status = sltbl_pkg::ST_NONE;
    // first stored key not below the probe, or the count if there is none
    pos = 0;
    while (pos < node_used && node_keys[pos] < $signed(k))
      pos++;
    case (op)
      sltbl_pkg::FUNC_INSERT: begin
        if (node_used >= sltbl_pkg::CAPACITY) begin
          res.status = sltbl_pkg::ST_FULL;
        end else begin
          for (int j = node_used; j > pos; j--) begin
            node_keys[j]  = node_keys[j-1];
            node_pages[j] = node_pages[j-1];
            node_slots[j] = node_slots[j-1];
          end
          node_keys[pos]  = $signed(k);
          node_pages[pos] = pg;
          node_slots[pos] = sl;
          node_used++;
          res.status      = sltbl_pkg::ST_OK;
          res.found_index = pos[5:0];
        end
      end
      sltbl_pkg::FUNC_LOCATE: begin
        if (pos < node_used) begin
          res.status      = sltbl_pkg::ST_OK;
          res.found_index = pos[5:0];
        end
      end
      sltbl_pkg::FUNC_READ: begin
        if (int'(ix) < node_used) begin
          res.status      = sltbl_pkg::ST_OK;
          res.found_index = ix;
          res.out_key     = node_keys[ix];
          res.out_page    = node_pages[ix];
          res.out_slot    = node_slots[ix];
        end
      end
      default: ;  // unused code leaves the node alone
    endcase
    res.entry_count = node_used[6:0];
    return res;
  endfunction

  // queue one operation and keep the generation-time fill level up to date
  function automatic void queue_op(logic [1:0] op, logic [31:0] k, logic [30:0] pg,
                                   logic [30:0] sl, logic [5:0] ix, bit drain);
    leaf_op_t item;
    item.func  = op;
    item.key   = k;
    item.page  = pg;
    item.slot  = sl;
    item.idx   = ix;
    item.drain = drain;
    item.phase = 0;
    op_queue.push_back(item);
    if (op == sltbl_pkg::FUNC_INSERT && gen_used < sltbl_pkg::CAPACITY) begin
      gen_used++;
      key_pool.push_back(k);
    end
  endfunction

  // key for an insert or locate: often one already stored, or close to one
  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    int          r;
    k = $urandom;
    r = $urandom_range(0, 99);
    if (r < 35 && key_pool.size() != 0)
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else if (r < 50 && key_pool.size() != 0)
      k = key_pool[$urandom_range(0, key_pool.size() - 1)] + ($urandom_range(0, 1) ? 1 : -1);
    else if (r < 65)
      k = $urandom_range(0, 16) - 8;
    else if (r < 70)
      k = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    return k;
  endfunction

  // record id half: mostly random, now and then an extreme
  function automatic logic [30:0] pick_rec();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return r[30:0];
    endcase
  endfunction

  // report a bad or unexpected result; only the first few are printed
  task automatic flag_result(bit have_exp, leaf_result_t exp, leaf_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      if (!have_exp)
        $display("[%0d] unexpected result: status %0d idx %0d key %0d page %0h slot %0h cnt %0d",
                 cycle_cnt, got.status, got.found_index, $signed(got.out_key),
                 got.out_page, got.out_slot, got.entry_count);
      else
        $display("[%0d] mismatch: exp status %0d idx %0d key %0d page %0h slot %0h cnt %0d",
                 cycle_cnt, exp.status, exp.found_index, $signed(exp.out_key),
                 exp.out_page, exp.out_slot, exp.entry_count,
                 "\n          got status %0d idx %0d key %0d page %0h slot %0h cnt %0d",
                 got.status, got.found_index, $signed(got.out_key),
                 got.out_page, got.out_slot, got.entry_count);
    end
  endtask

  // --------------------------------------------------------------------------
  // clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver: falling edge, one transaction in flight on the input channel
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle[cur_phase]);
      // a presented transaction stays put until the block takes it
      if (!in_valid || n_accepted == n_presented) begin
        if (op_queue.size() != 0
            && !(op_queue[0].drain && owed_results.size() != 0)
            && $urandom_range(0, 99) >= send_idle[op_queue[0].phase]) begin
          func        <= op_queue[0].func;
          key         <= op_queue[0].key;
          rec_page    <= op_queue[0].page;
          rec_slot    <= op_queue[0].slot;
          entry_index <= op_queue[0].idx;
          cur_phase   <= op_queue[0].phase;
          in_valid    <= 1'b1;
          void'(op_queue.pop_front());
          n_presented++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitors: rising edge; accepted inputs feed the mirror, outputs are checked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      owed_results.push_back(leaf_node_apply(func, key, rec_page, rec_slot, entry_index));
      n_accepted++;
    end
  end

  always @(posedge clk) begin
    leaf_result_t got;
    leaf_result_t exp;
    if (!rst && out_valid && out_ready) begin
      got = '{status, found_index, out_key, out_page, out_slot, entry_count};
      if (owed_results.size() == 0) begin
        flag_result(1'b0, got, got);
      end else begin
        exp = owed_results.pop_front();
        if (got !== exp)
          flag_result(1'b1, exp, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0]  op;
    logic [31:0] k;
    logic [5:0]  ix;
    int          r;
    int          n_ops;

    rst         = 1'b1;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    func        = '0;
    key         = '0;
    rec_page    = '0;
    rec_slot    = '0;
    entry_index = '0;
    node_used   = 0;
    gen_used    = 0;
    n_presented = 0;
    n_accepted  = 0;
    mismatch_cnt = 0;
    cycle_cnt   = 0;
    cur_phase   = 0;

    // directed: empty node, then a handful of entries with extreme contents
    queue_op(sltbl_pkg::FUNC_LOCATE, 32'd0, '0, '0, '0, 1'b0);             // empty node
    queue_op(sltbl_pkg::FUNC_READ,   32'd0, '0, '0, 6'd0, 1'b0);           // empty node
    queue_op(FUNC_UNUSED, '1, '1, '1, '1, 1'b0);
    queue_op(sltbl_pkg::FUNC_INSERT, 32'd0, '0, '0, '1, 1'b0);
    queue_op(sltbl_pkg::FUNC_LOCATE, 32'd5, '1, '1, '1, 1'b0);             // past every key
    queue_op(sltbl_pkg::FUNC_LOCATE, 32'd0, '0, '0, '0, 1'b0);
    queue_op(sltbl_pkg::FUNC_INSERT, 32'h7fff_ffff, '1, '1, '0, 1'b0);
    queue_op(sltbl_pkg::FUNC_INSERT, 32'h8000_0000, 31'h2aaa_aaaa, 31'h5555_5555, '0, 1'b0);
    queue_op(sltbl_pkg::FUNC_INSERT, 32'd0, 31'h5555_5555, 31'h2aaa_aaaa, '0,
             1'b0); // equal key
    queue_op(sltbl_pkg::FUNC_INSERT, 32'hffff_ffff, 31'd1, 31'd1, '0, 1'b0);
    queue_op(sltbl_pkg::FUNC_LOCATE, 32'h8000_0000, '0, '0, '0, 1'b0);
    queue_op(sltbl_pkg::FUNC_LOCATE, 32'h7fff_ffff, '0, '0, '0, 1'b0);
    queue_op(sltbl_pkg::FUNC_LOCATE, 32'd1, '0, '0, '0, 1'b0);
    for (int i = 0; i < 5; i++)
      queue_op(sltbl_pkg::FUNC_READ, '0, '0, '0, i[5:0], 1'b0);
    queue_op(sltbl_pkg::FUNC_READ, '0, '0, '0, 6'd5, 1'b0);                // index at the count
    queue_op(sltbl_pkg::FUNC_READ, '0, '0, '0, 6'd63, 1'b0);
    queue_op(FUNC_UNUSED, $urandom, pick_rec(), pick_rec(), 6'($urandom), 1'b0);

    // random: inserts fill the node part way through, then keep reporting full
    for (int i = 0; i < RANDOM_OPS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      op = sltbl_pkg::FUNC_INSERT;
      else if (r < 58) op = sltbl_pkg::FUNC_LOCATE;
      else if (r < 92) op = sltbl_pkg::FUNC_READ;
      else             op = FUNC_UNUSED;
      k  = pick_key();
      ix = 6'($urandom);
      if (op == sltbl_pkg::FUNC_READ && gen_used != 0 && $urandom_range(0, 9) < 7)
        ix = 6'($urandom_range(0, gen_used - 1));
      // the first random transaction, and a few more, wait for the block to drain
      queue_op(op, k, pick_rec(), pick_rec(), ix, (i == 0) || ($urandom_range(0, 99) < 2));
    end

    // split the run into the three idling phases
    n_ops = op_queue.size();
    for (int i = 0; i < n_ops; i++)
      op_queue[i].phase = (i * 3) / n_ops;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || n_accepted != n_presented)
      @(posedge clk);
    while (owed_results.size() != 0)
      @(posedge clk);
    // let any stray result show up before the verdict
    repeat (SETTLE_TIME) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sltbl_pkg.sv
rtl/sltbl_ram.sv
rtl/sltbl_cmp.sv
rtl/sorted_leaf_node_table.sv
dv/tb_sorted_leaf_node_table.sv
